[hw/rtl/bsbp_pkg.sv]
// Shared types and constants of the box screen bounds projector.
package bsbp_pkg;

    localparam int POS_W  = 32;
    localparam int HALF_W = 31;
    localparam int P_W    = 33;
    localparam int C_W    = 34;
    localparam int ROT_W  = 16;
    localparam int PROD_W = 50;
    localparam int DOT_W  = 52;
    localparam int NINE_W = 56;
    localparam int Q_W    = 17;
    localparam int SL_W   = 18;
    localparam int SP_W   = 20;
    localparam int OFF_W  = 39;
    localparam int WID_W  = 40;
    localparam int RES_W  = 16;
    localparam int DIV_FRAC = 13;
    localparam int DIV_RW   = 68;

    localparam logic signed [DOT_W-1:0] CLIP_DIST = DOT_W'(26 * 16384);
    localparam logic signed [WID_W-1:0] MIN_WIDTH = WID_W'(4 * 1048576);
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam logic [SP_W-1:0] STEP_PIXEL_RESET = SP_W'(138240);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW_X     = 4'd0,
        CFG_ROT_ROW_Y     = 4'd1,
        CFG_ROT_ROW_Z     = 4'd2,
        CFG_CAM_POS_X     = 4'd3,
        CFG_CAM_POS_Y     = 4'd4,
        CFG_CAM_POS_Z     = 4'd5,
        CFG_STEP_PIXEL    = 4'd6,
        CFG_SCREEN_CENTRE = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] box_centre_x;
        logic signed [POS_W-1:0] box_centre_y;
        logic signed [POS_W-1:0] box_centre_z;
        logic [HALF_W-1:0]       half_extent_x;
        logic [HALF_W-1:0]       half_extent_y;
        logic [HALF_W-1:0]       half_extent_z;
    } box_req_t;

    typedef struct packed {
        logic                    visible;
        logic signed [RES_W-1:0] rect_min_x;
        logic signed [RES_W-1:0] rect_min_y;
        logic signed [RES_W-1:0] rect_max_x;
        logic signed [RES_W-1:0] rect_max_y;
    } rect_t;

    // Box relative to the camera, as queued between front and back.
    typedef struct packed {
        logic signed [P_W-1:0] p_x;
        logic signed [P_W-1:0] p_y;
        logic signed [P_W-1:0] p_z;
        logic [HALF_W-1:0]     h_x;
        logic [HALF_W-1:0]     h_y;
        logic [HALF_W-1:0]     h_z;
    } box_rel_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic rej;
        logic neg_x;
        logic neg_y;
    } corner_tag_t;

    typedef struct packed {
        logic                    valid;
        logic                    first;
        logic                    last;
        logic                    rej;
        logic signed [OFF_W-1:0] x;
        logic signed [OFF_W-1:0] y;
    } corner_t;

endpackage

[hw/rtl/box_screen_bounds_projector_top.sv]
// Box screen bounds projector: a box in, one screen rectangle or a reject out.
// Throughput: the corner walk takes the next box after the eighth corner of the last
// one while a result slot is free, and sends one corner per cycle through the shared
// rotation stage and the two 17-stage slope dividers.
// Reset clears both queues and loads the register defaults (step_pixel 540.0).
module box_screen_bounds_projector_top #(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  bsbp_pkg::box_req_t                box,
    output logic                              empty,
    input  logic                              pop,
    output bsbp_pkg::rect_t                   rect,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    logic [bsbp_pkg::CFG_DATA_W-1:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [bsbp_pkg::POS_W-1:0]      cam_x_reg, cam_y_reg, cam_z_reg;
    logic [bsbp_pkg::SP_W-1:0]       step_pixel_reg;
    logic [31:0]                     centre_reg;

    logic               rel_valid;
    bsbp_pkg::box_rel_t rel;
    logic               rel_take;
    logic               credit_ok;
    bsbp_pkg::corner_t  corner;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg      <= '0;
            rot_y_reg      <= '0;
            rot_z_reg      <= '0;
            cam_x_reg      <= '0;
            cam_y_reg      <= '0;
            cam_z_reg      <= '0;
            step_pixel_reg <= bsbp_pkg::STEP_PIXEL_RESET;
            centre_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bsbp_pkg::CFG_ROT_ROW_X:     rot_x_reg      <= cfg_data;
                bsbp_pkg::CFG_ROT_ROW_Y:     rot_y_reg      <= cfg_data;
                bsbp_pkg::CFG_ROT_ROW_Z:     rot_z_reg      <= cfg_data;
                bsbp_pkg::CFG_CAM_POS_X:     cam_x_reg      <= cfg_data[bsbp_pkg::POS_W-1:0];
                bsbp_pkg::CFG_CAM_POS_Y:     cam_y_reg      <= cfg_data[bsbp_pkg::POS_W-1:0];
                bsbp_pkg::CFG_CAM_POS_Z:     cam_z_reg      <= cfg_data[bsbp_pkg::POS_W-1:0];
                bsbp_pkg::CFG_STEP_PIXEL:    step_pixel_reg <= cfg_data[bsbp_pkg::SP_W-1:0];
                bsbp_pkg::CFG_SCREEN_CENTRE: centre_reg     <= cfg_data[31:0];
                default:                     ;
            endcase
        end
    end

    bsbp_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .box       (box),
        .cam_x     (cam_x_reg),
        .cam_y     (cam_y_reg),
        .cam_z     (cam_z_reg),
        .rel_valid (rel_valid),
        .rel       (rel),
        .rel_take  (rel_take)
    );

    bsbp_xform u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .rel_valid  (rel_valid),
        .rel        (rel),
        .rel_take   (rel_take),
        .credit_ok  (credit_ok),
        .rot_x      (rot_x_reg),
        .rot_y      (rot_y_reg),
        .rot_z      (rot_z_reg),
        .step_pixel (step_pixel_reg),
        .corner     (corner)
    );

    bsbp_collect #(
        .DEPTH (OUT_DEPTH)
    ) u_collect (
        .clk           (clk),
        .rst_n         (rst_n),
        .corner        (corner),
        .step_pixel    (step_pixel_reg),
        .screen_centre (centre_reg),
        .issue         (rel_take),
        .credit_ok     (credit_ok),
        .empty         (empty),
        .pop           (pop),
        .rect          (rect)
    );

endmodule

[hw/rtl/bsbp_front.sv]
// Front end: accepts boxes, subtracts the camera position and queues them.
module bsbp_front #(
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  bsbp_pkg::box_req_t         box,
    input  logic [bsbp_pkg::POS_W-1:0] cam_x,
    input  logic [bsbp_pkg::POS_W-1:0] cam_y,
    input  logic [bsbp_pkg::POS_W-1:0] cam_z,
    output logic                       rel_valid,
    output bsbp_pkg::box_rel_t         rel,
    input  logic                       rel_take
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsbp_pkg::box_rel_t mem_reg [DEPTH];
    bsbp_pkg::box_rel_t entry;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_push   = push && !full;
    assign rel_valid = (count_reg != '0);
    assign rel       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        entry.p_x = $signed({box.box_centre_x[bsbp_pkg::POS_W-1], box.box_centre_x})
                  - $signed({cam_x[bsbp_pkg::POS_W-1], cam_x});
        entry.p_y = $signed({box.box_centre_y[bsbp_pkg::POS_W-1], box.box_centre_y})
                  - $signed({cam_y[bsbp_pkg::POS_W-1], cam_y});
        entry.p_z = $signed({box.box_centre_z[bsbp_pkg::POS_W-1], box.box_centre_z})
                  - $signed({cam_z[bsbp_pkg::POS_W-1], cam_z});
        entry.h_x = box.half_extent_x;
        entry.h_y = box.half_extent_y;
        entry.h_z = box.half_extent_z;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rel_take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !rel_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && rel_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

[hw/rtl/bsbp_div.sv]
// Pipelined restoring divider giving the magnitude of a slope with 13 extra fraction bits.
module bsbp_div (
    input  logic                       clk,
    input  logic [bsbp_pkg::DOT_W-1:0] num,
    input  logic [bsbp_pkg::DOT_W-1:0] den,
    output logic [bsbp_pkg::Q_W-1:0]   quot
);
    localparam int NS = bsbp_pkg::Q_W;
    localparam int RW = bsbp_pkg::DIV_RW;

    logic [RW-1:0]                    rem_reg [NS];
    logic [RW-1:0]                    rem_next [NS];
    logic [bsbp_pkg::DOT_W-1:0]       den_reg [NS];
    logic [bsbp_pkg::DOT_W-1:0]       den_next [NS];
    logic [NS-1:0]                    q_reg [NS];
    logic [NS-1:0]                    q_next [NS];

    // Stage s settles quotient bit NS-1-s.
    always_comb
    begin
        logic [RW-1:0]              src_rem;
        logic [RW-1:0]              trial;
        logic [bsbp_pkg::DOT_W-1:0] src_den;
        logic [NS-1:0]              src_q;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                src_rem = RW'(num) << bsbp_pkg::DIV_FRAC;
                src_den = den;
                src_q   = '0;
            end
            else
            begin
                src_rem = rem_reg[s-1];
                src_den = den_reg[s-1];
                src_q   = q_reg[s-1];
            end
            trial       = RW'(src_den) << (NS - 1 - s);
            den_next[s] = src_den;
            if (src_rem >= trial)
            begin
                rem_next[s] = src_rem - trial;
                q_next[s]   = src_q | (NS'(1) << (NS - 1 - s));
            end
            else
            begin
                rem_next[s] = src_rem;
                q_next[s]   = src_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_next[s];
            q_reg[s]   <= q_next[s];
        end
    end

    assign quot = q_reg[NS-1];

endmodule

[hw/rtl/bsbp_xform.sv]
// Back end pipeline: walks the eight corners, rotates, clips and projects each one.
module bsbp_xform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rel_valid,
    input  bsbp_pkg::box_rel_t            rel,
    output logic                          rel_take,
    input  logic                          credit_ok,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0] rot_x,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0] rot_y,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0] rot_z,
    input  logic [bsbp_pkg::SP_W-1:0]     step_pixel,
    output bsbp_pkg::corner_t             corner
);
    localparam int NS = bsbp_pkg::Q_W;

    bsbp_pkg::box_rel_t cur_box_reg;
    logic               cur_valid_reg;
    logic [2:0]         k_reg;

    bsbp_pkg::corner_tag_t sa_tag_reg, sb_tag_reg, sc_tag_reg, sd_tag_reg;
    bsbp_pkg::corner_tag_t sa_tag_next, sd_tag_next;
    logic signed [bsbp_pkg::C_W-1:0]    sa_c_reg [3];
    logic signed [bsbp_pkg::C_W-1:0]    sa_c_next [3];
    logic signed [bsbp_pkg::PROD_W-1:0] sb_prod_reg [9];
    logic signed [bsbp_pkg::PROD_W-1:0] sb_prod_next [9];
    logic signed [bsbp_pkg::DOT_W-1:0]  sc_tx_reg, sc_ty_reg, sc_d_reg;
    logic [bsbp_pkg::DOT_W-1:0]         sd_magx_reg, sd_magy_reg, sd_den_reg;
    logic [bsbp_pkg::DOT_W-1:0]         sd_magx_next, sd_magy_next;
    bsbp_pkg::corner_tag_t              dly_tag_reg [NS];
    logic [bsbp_pkg::Q_W-1:0]           quot_x, quot_y;
    bsbp_pkg::corner_t                  corner_reg, corner_next;
    logic                               corner_valid_reg;

    logic [bsbp_pkg::CFG_DATA_W-1:0]    rows [3];

    assign rows[0] = rot_x;
    assign rows[1] = rot_y;
    assign rows[2] = rot_z;

    assign rel_take = rel_valid && credit_ok && (!cur_valid_reg || k_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else if (rel_take)
        begin
            cur_valid_reg <= 1'b1;
            k_reg         <= '0;
        end
        else if (cur_valid_reg)
        begin
            k_reg <= k_reg + 1'b1;
            if (k_reg == 3'd7)
            begin
                cur_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rel_take)
        begin
            cur_box_reg <= rel;
        end
    end

    // Corner k takes +h on x, y, z where bits 2, 1, 0 of k are set.
    always_comb
    begin
        sa_tag_next       = '0;
        sa_tag_next.valid = cur_valid_reg;
        sa_tag_next.first = (k_reg == 3'd0);
        sa_tag_next.last  = (k_reg == 3'd7);
        sa_c_next[0] = k_reg[2]
            ? bsbp_pkg::C_W'(cur_box_reg.p_x) + $signed({3'b000, cur_box_reg.h_x})
            : bsbp_pkg::C_W'(cur_box_reg.p_x) - $signed({3'b000, cur_box_reg.h_x});
        sa_c_next[1] = k_reg[1]
            ? bsbp_pkg::C_W'(cur_box_reg.p_y) + $signed({3'b000, cur_box_reg.h_y})
            : bsbp_pkg::C_W'(cur_box_reg.p_y) - $signed({3'b000, cur_box_reg.h_y});
        sa_c_next[2] = k_reg[0]
            ? bsbp_pkg::C_W'(cur_box_reg.p_z) + $signed({3'b000, cur_box_reg.h_z})
            : bsbp_pkg::C_W'(cur_box_reg.p_z) - $signed({3'b000, cur_box_reg.h_z});
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sb_prod_next[r*3+j] = bsbp_pkg::PROD_W'(sa_c_reg[j])
                    * bsbp_pkg::PROD_W'($signed(rows[r][16*j +: bsbp_pkg::ROT_W]));
            end
        end
    end

    always_comb
    begin
        logic signed [bsbp_pkg::NINE_W-1:0] nine_d;
        logic signed [bsbp_pkg::NINE_W-1:0] tx_w;
        logic signed [bsbp_pkg::NINE_W-1:0] ty_w;
        nine_d = (bsbp_pkg::NINE_W'(sc_d_reg) <<< 3) + bsbp_pkg::NINE_W'(sc_d_reg);
        tx_w   = bsbp_pkg::NINE_W'(sc_tx_reg);
        ty_w   = bsbp_pkg::NINE_W'(sc_ty_reg);
        sd_tag_next       = sc_tag_reg;
        sd_tag_next.neg_x = sc_tx_reg[bsbp_pkg::DOT_W-1];
        sd_tag_next.neg_y = sc_ty_reg[bsbp_pkg::DOT_W-1];
        sd_tag_next.rej   = (sc_d_reg < bsbp_pkg::CLIP_DIST)
                          || (tx_w > nine_d) || (tx_w < -nine_d)
                          || (ty_w > nine_d) || (ty_w < -nine_d);
        sd_magx_next = sc_tx_reg[bsbp_pkg::DOT_W-1] ? -sc_tx_reg : sc_tx_reg;
        sd_magy_next = sc_ty_reg[bsbp_pkg::DOT_W-1] ? -sc_ty_reg : sc_ty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_tag_reg <= '0;
            sb_tag_reg <= '0;
            sc_tag_reg <= '0;
            sd_tag_reg <= '0;
            for (int s = 0; s < NS; s++)
            begin
                dly_tag_reg[s] <= '0;
            end
            corner_valid_reg <= 1'b0;
        end
        else
        begin
            sa_tag_reg     <= sa_tag_next;
            sb_tag_reg     <= sa_tag_reg;
            sc_tag_reg     <= sb_tag_reg;
            sd_tag_reg     <= sd_tag_next;
            dly_tag_reg[0] <= sd_tag_reg;
            for (int s = 1; s < NS; s++)
            begin
                dly_tag_reg[s] <= dly_tag_reg[s-1];
            end
            corner_valid_reg <= corner_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            sa_c_reg[j] <= sa_c_next[j];
        end
        for (int i = 0; i < 9; i++)
        begin
            sb_prod_reg[i] <= sb_prod_next[i];
        end
        sc_tx_reg   <= bsbp_pkg::DOT_W'(sb_prod_reg[0]) + bsbp_pkg::DOT_W'(sb_prod_reg[1])
                     + bsbp_pkg::DOT_W'(sb_prod_reg[2]);
        sc_ty_reg   <= bsbp_pkg::DOT_W'(sb_prod_reg[3]) + bsbp_pkg::DOT_W'(sb_prod_reg[4])
                     + bsbp_pkg::DOT_W'(sb_prod_reg[5]);
        sc_d_reg    <= -(bsbp_pkg::DOT_W'(sb_prod_reg[6]) + bsbp_pkg::DOT_W'(sb_prod_reg[7])
                     + bsbp_pkg::DOT_W'(sb_prod_reg[8]));
        sd_magx_reg <= sd_magx_next;
        sd_magy_reg <= sd_magy_next;
        sd_den_reg  <= sc_d_reg;
        corner_reg  <= corner_next;
    end

    bsbp_div u_div_x (
        .clk  (clk),
        .num  (sd_magx_reg),
        .den  (sd_den_reg),
        .quot (quot_x)
    );

    bsbp_div u_div_y (
        .clk  (clk),
        .num  (sd_magy_reg),
        .den  (sd_den_reg),
        .quot (quot_y)
    );

    // Round the extra quotient bit half away from zero, then scale to pixels.
    always_comb
    begin
        logic [bsbp_pkg::Q_W-1:0]         mag_x, mag_y;
        logic signed [bsbp_pkg::SL_W-1:0] sl_x, sl_y;
        logic signed [bsbp_pkg::OFF_W-1:0] sp_w;
        bsbp_pkg::corner_tag_t            t;
        t     = dly_tag_reg[NS-1];
        mag_x = bsbp_pkg::Q_W'(({1'b0, quot_x} + 1'b1) >> 1);
        mag_y = bsbp_pkg::Q_W'(({1'b0, quot_y} + 1'b1) >> 1);
        sl_x  = t.neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
        sl_y  = t.neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
        sp_w  = $signed({{(bsbp_pkg::OFF_W - bsbp_pkg::SP_W){1'b0}}, step_pixel});
        corner_next.valid = t.valid;
        corner_next.first = t.first;
        corner_next.last  = t.last;
        corner_next.rej   = t.rej;
        corner_next.x     = bsbp_pkg::OFF_W'(sl_x) * sp_w;
        corner_next.y     = bsbp_pkg::OFF_W'(sl_y) * sp_w;
    end

    always_comb
    begin
        corner       = corner_reg;
        corner.valid = corner_valid_reg;
    end

endmodule

[hw/rtl/bsbp_collect.sv]
// Gathers corner offsets into a rectangle, checks its size and queues the result.
module bsbp_collect #(
    parameter int DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsbp_pkg::corner_t           corner,
    input  logic [bsbp_pkg::SP_W-1:0]   step_pixel,
    input  logic [31:0]                 screen_centre,
    input  logic                        issue,
    output logic                        credit_ok,
    output logic                        empty,
    input  logic                        pop,
    output bsbp_pkg::rect_t             rect
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                               ok_reg, ok_next;
    logic                               fin_reg;
    logic signed [bsbp_pkg::OFF_W-1:0]  minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [bsbp_pkg::OFF_W-1:0]  minx_next, maxx_next, miny_next, maxy_next;
    bsbp_pkg::rect_t                    mem_reg [DEPTH];
    bsbp_pkg::rect_t                    res;
    logic [PTR_W-1:0]                   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   owed_reg, owed_next;
    logic                               do_pop;

    function automatic logic [bsbp_pkg::RES_W-1:0] place(
        input logic signed [bsbp_pkg::OFF_W-1:0] v,
        input logic [bsbp_pkg::RES_W-1:0]        c
    );
        logic [bsbp_pkg::OFF_W-1:0] mag;
        logic [bsbp_pkg::OFF_W-1:0] rnd;
        mag = v[bsbp_pkg::OFF_W-1] ? -v : v;
        rnd = (mag + bsbp_pkg::OFF_W'(1 << 19)) >> 20;
        if (v[bsbp_pkg::OFF_W-1])
        begin
            rnd = -rnd;
        end
        return c + rnd[bsbp_pkg::RES_W-1:0];
    endfunction

    always_comb
    begin
        ok_next   = ok_reg;
        minx_next = minx_reg;
        maxx_next = maxx_reg;
        miny_next = miny_reg;
        maxy_next = maxy_reg;
        if (corner.valid)
        begin
            if (corner.first)
            begin
                ok_next   = !corner.rej;
                minx_next = corner.x;
                maxx_next = corner.x;
                miny_next = corner.y;
                maxy_next = corner.y;
            end
            else
            begin
                ok_next = ok_reg && !corner.rej;
                if (corner.x < minx_reg) minx_next = corner.x;
                if (corner.x > maxx_reg) maxx_next = corner.x;
                if (corner.y < miny_reg) miny_next = corner.y;
                if (corner.y > maxy_reg) maxy_next = corner.y;
            end
        end
    end

    always_comb
    begin
        logic signed [bsbp_pkg::WID_W-1:0] w, h, big;
        logic                              keep;
        w    = bsbp_pkg::WID_W'(maxx_reg) - bsbp_pkg::WID_W'(minx_reg);
        h    = bsbp_pkg::WID_W'(maxy_reg) - bsbp_pkg::WID_W'(miny_reg);
        big  = $signed({{(bsbp_pkg::WID_W - bsbp_pkg::SP_W){1'b0}}, step_pixel}) <<< 14;
        keep = ok_reg && !(w < bsbp_pkg::MIN_WIDTH) && !(w > big)
                      && !(h < bsbp_pkg::MIN_WIDTH) && !(h > big);
        res  = '0;
        if (keep)
        begin
            res.visible    = 1'b1;
            res.rect_min_x = place(minx_reg, screen_centre[15:0]);
            res.rect_min_y = place(miny_reg, screen_centre[31:16]);
            res.rect_max_x = place(maxx_reg, screen_centre[15:0]);
            res.rect_max_y = place(maxy_reg, screen_centre[31:16]);
        end
    end

    // Each box taken by the corner walk reserves one result slot until popped.
    assign do_pop    = pop && !empty;
    assign empty     = (count_reg == '0);
    assign rect      = mem_reg[rd_ptr_reg];
    assign credit_ok = (owed_reg < CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        owed_next  = owed_reg;
        if (fin_reg && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!fin_reg && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
        if (issue && !do_pop)
        begin
            owed_next = owed_reg + 1'b1;
        end
        else if (!issue && do_pop)
        begin
            owed_next = owed_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            owed_reg   <= '0;
        end
        else
        begin
            fin_reg   <= corner.valid && corner.last;
            count_reg <= count_next;
            owed_reg  <= owed_next;
            if (fin_reg)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        minx_reg <= minx_next;
        maxx_reg <= maxx_next;
        miny_reg <= miny_next;
        maxy_reg <= maxy_next;
        if (fin_reg)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule
